>>> sv/hhp_pkg.sv
`timescale 1ns / 1ps
package hhp_pkg;

    localparam int LENGTH_BITS = 31;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_EOF     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_COMPLETE   = 2'd1;
    localparam logic [1:0] ST_FAULT      = 2'd2;

    localparam logic [2:0] P_F0    = 3'd0;
    localparam logic [2:0] P_F1    = 3'd1;
    localparam logic [2:0] P_F2    = 3'd2;
    localparam logic [2:0] P_LEAD  = 3'd3;
    localparam logic [2:0] P_KEY   = 3'd4;
    localparam logic [2:0] P_VLEAD = 3'd5;
    localparam logic [2:0] P_VAL   = 3'd6;

    localparam logic [1:0] NP_SKIP = 2'd0;
    localparam logic [1:0] NP_DIG  = 2'd1;
    localparam logic [1:0] NP_DONE = 2'd2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [14*8-1:0] K_CLEN  = "content-length";
    localparam logic [4*8-1:0]  K_HOST  = "host";
    localparam logic [12*8-1:0] K_CTYPE = "content-type";
    localparam logic [10*8-1:0] K_CONN  = "connection";
    localparam logic [5*8-1:0]  T_HTTP  = "HTTP/";
    localparam logic [4*8-1:0]  T_POST  = "POST";
    localparam logic [3*8-1:0]  T_V10   = "1.0";
    localparam logic [3*8-1:0]  T_V11   = "1.1";
    localparam logic [10*8-1:0] T_KEEP  = "keep-alive";
    localparam logic [5*8-1:0]  T_CLOSE = "close";

    typedef struct packed {
        logic [2:0]             phase;
        logic [3:0]             line_pos;
        logic [3:0]             kmf;
        logic [1:0]             vmf;
        logic                   trail_ws;
        logic [LENGTH_BITS-1:0] accum;
        logic                   sign;
        logic [1:0]             num_phase;
        logic [5:0]             seen;
        logic [1:0]             status;
        logic                   keep_alive;
    } t_st;

    localparam t_st ST_RESET = '{phase: P_F0, line_pos: 4'd0, kmf: 4'hF, vmf: 2'b11,
        trail_ws: 1'b0, accum: '0, sign: 1'b0, num_phase: NP_SKIP, seen: 6'd0,
        status: ST_INCOMPLETE, keep_alive: 1'b1};

    function automatic logic [7:0] lc(input logic [7:0] c);
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic blank(input logic [7:0] c);
        blank = (c == " ") || (c == 8'h09);
    endfunction

    function automatic logic [3:0] pinc(input logic [3:0] p);
        pinc = (p == 4'd15) ? p : p + 4'd1;
    endfunction

    // True when c equals character p of the n-character text t.
    function automatic logic chr_eq(input logic [14*8-1:0] t, input int n,
                                    input logic [3:0] p, input logic [7:0] c);
        logic [7:0] ch;
        ch = 8'd0;
        if (int'(p) < n) ch = t[(n-1-int'(p))*8 +: 8];
        chr_eq = (int'(p) < n) && (ch == c);
    endfunction

    function automatic t_st fold_version(input t_st s);
        t_st r;
        r = s;
        if (s.line_pos < 4'd5 || !s.kmf[1]) r.kmf[3:1] = 3'b000;
        if (s.line_pos != 4'd8) r.kmf[3:2] = 2'b00;
        fold_version = r;
    endfunction

    function automatic t_st track_version(input t_st s, input logic [7:0] c);
        t_st r;
        r = s;
        if (s.line_pos < 4'd5) begin
            if (!chr_eq(112'(T_HTTP), 5, s.line_pos, c)) r.kmf[1] = 1'b0;
        end else if (s.line_pos < 4'd8) begin
            if (!chr_eq(112'(T_V10), 3, s.line_pos - 4'd5, c)) r.kmf[2] = 1'b0;
            if (!chr_eq(112'(T_V11), 3, s.line_pos - 4'd5, c)) r.kmf[3] = 1'b0;
        end else begin
            r.kmf[3:2] = 2'b00;
        end
        r.line_pos = pinc(s.line_pos);
        track_version = r;
    endfunction

    function automatic t_st key_char(input t_st s, input logic [7:0] c);
        t_st r;
        logic [7:0] l;
        r = s;
        l = lc(c);
        if (c == ":") begin
            if (s.line_pos != 4'd14) r.kmf[0] = 1'b0;
            if (s.line_pos != 4'd4)  r.kmf[1] = 1'b0;
            if (s.line_pos != 4'd12) r.kmf[2] = 1'b0;
            if (s.line_pos != 4'd10) r.kmf[3] = 1'b0;
            r.phase = P_VLEAD;
            r.line_pos = 4'd0;
            r.vmf = 2'b11;
            r.trail_ws = 1'b0;
            r.sign = 1'b0;
            r.num_phase = NP_SKIP;
            if (r.kmf[0] && !s.seen[0]) r.accum = '0;
        end else begin
            if (!chr_eq(K_CLEN, 14, s.line_pos, l))        r.kmf[0] = 1'b0;
            if (!chr_eq(112'(K_HOST), 4, s.line_pos, l))   r.kmf[1] = 1'b0;
            if (!chr_eq(112'(K_CTYPE), 12, s.line_pos, l)) r.kmf[2] = 1'b0;
            if (!chr_eq(112'(K_CONN), 10, s.line_pos, l))  r.kmf[3] = 1'b0;
            r.line_pos = pinc(s.line_pos);
        end
        key_char = r;
    endfunction

    function automatic t_st value_char(input t_st s, input logic [7:0] c);
        t_st r;
        logic dig;
        logic feed;
        logic [LENGTH_BITS+3:0] prod;
        logic [7:0] l;
        r = s;
        dig = (c >= "0") && (c <= "9");
        feed = 1'b0;
        unique case (s.num_phase)
            NP_SKIP: begin
                if (blank(c) || (c >= 8'd10 && c <= 8'd13)) begin
                    feed = 1'b0;
                end else if (c == "+" || c == "-") begin
                    r.sign = (c == "-");
                    r.num_phase = NP_DIG;
                end else if (!dig) begin
                    r.num_phase = NP_DONE;
                end else begin
                    r.num_phase = NP_DIG;
                    feed = 1'b1;
                end
            end
            NP_DIG: begin
                if (!dig) r.num_phase = NP_DONE;
                else feed = 1'b1;
            end
            default: feed = 1'b0;
        endcase
        if (feed && s.kmf[0] && !s.seen[0]) begin
            prod = ({4'd0, s.accum} << 3) + ({4'd0, s.accum} << 1)
                 + (LENGTH_BITS+4)'(c - "0");
            r.accum = (prod > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX
                                                         : prod[LENGTH_BITS-1:0];
        end
        if (blank(c)) begin
            r.trail_ws = 1'b1;
        end else begin
            if (s.trail_ws) r.vmf = 2'b00;
            r.trail_ws = 1'b0;
            l = lc(c);
            if (!chr_eq(112'(T_KEEP), 10, s.line_pos, l)) r.vmf[0] = 1'b0;
            if (!chr_eq(112'(T_CLOSE), 5, s.line_pos, l)) r.vmf[1] = 1'b0;
            r.line_pos = pinc(s.line_pos);
        end
        value_char = r;
    endfunction

    function automatic t_st content_char(input t_st s, input logic [7:0] c,
                                         input logic req);
        t_st r;
        r = s;
        unique case (s.phase)
            P_F0, P_F1: begin
                if (c == " ") begin
                    if (s.phase == P_F0) begin
                        if (req) begin
                            if (s.line_pos != 4'd4) r.kmf[0] = 1'b0;
                        end else begin
                            r = fold_version(s);
                        end
                    end
                    r.phase = s.phase + 3'd1;
                    r.line_pos = 4'd0;
                end else if (s.phase == P_F0) begin
                    if (req) begin
                        if (!chr_eq(112'(T_POST), 4, s.line_pos, c)) r.kmf[0] = 1'b0;
                        r.line_pos = pinc(s.line_pos);
                    end else begin
                        r = track_version(s, c);
                    end
                end
            end
            P_F2: if (req) r = track_version(s, c);
            P_LEAD: begin
                if (blank(c)) begin
                    r.line_pos = pinc(s.line_pos);
                end else begin
                    r.phase = P_KEY;
                    r.line_pos = 4'd0;
                    r.kmf = 4'hF;
                    r = key_char(r, c);
                end
            end
            P_KEY:   r = key_char(s, c);
            P_VLEAD: if (!blank(c)) begin
                r.phase = P_VAL;
                r = value_char(r, c);
            end
            P_VAL:   r = value_char(s, c);
            default: r = s;
        endcase
        content_char = r;
    endfunction

    function automatic logic [1:0] verify(input t_st s, input logic req);
        if (req) begin
            if (s.seen[5:4] == 2'd2 && !s.seen[2]) verify = ST_FAULT;
            else if (!s.seen[0] && s.seen[3])      verify = ST_FAULT;
            else                                   verify = ST_COMPLETE;
        end else begin
            verify = s.seen[0] ? ST_COMPLETE : ST_FAULT;
        end
    endfunction

    function automatic t_st end_line(input t_st s, input logic req);
        t_st r;
        logic [1:0] vc;
        logic nxt;
        r = s;
        nxt = 1'b1;
        if (s.phase <= P_F2) begin
            if (s.phase != P_F2) begin
                r.status = ST_FAULT;
                nxt = 1'b0;
            end else begin
                if (req) begin
                    r = fold_version(r);
                    if (r.kmf[0]) r.seen[3] = 1'b1;
                end
                if (!r.kmf[1]) begin
                    r.status = ST_FAULT;
                    nxt = 1'b0;
                end else begin
                    vc = r.kmf[2] ? 2'd1 : (r.kmf[3] ? 2'd2 : 2'd0);
                    r.seen[5:4] = vc;
                    if (vc == 2'd1) r.keep_alive = 1'b0;
                end
            end
        end else if (s.phase == P_LEAD) begin
            r.status = (s.line_pos == 4'd0) ? verify(s, req) : ST_FAULT;
            nxt = 1'b0;
        end else if (s.phase != P_VAL) begin
            r.status = ST_FAULT;
            nxt = 1'b0;
        end else if (s.kmf[0]) begin
            if (s.seen[0] || (s.sign && s.accum != '0)) begin
                r.status = ST_FAULT;
                nxt = 1'b0;
            end else begin
                r.seen[0] = 1'b1;
            end
        end else if (s.kmf[1]) begin
            if (req) r.seen[2] = 1'b1;
        end else if (s.kmf[2]) begin
            if (s.seen[1]) begin
                r.status = ST_FAULT;
                nxt = 1'b0;
            end else begin
                r.seen[1] = 1'b1;
            end
        end else if (s.kmf[3]) begin
            if (s.vmf[0] && s.line_pos == 4'd10)     r.keep_alive = 1'b1;
            else if (s.vmf[1] && s.line_pos == 4'd5) r.keep_alive = 1'b0;
        end
        if (nxt) begin
            r.phase = P_LEAD;
            r.line_pos = 4'd0;
        end
        end_line = r;
    endfunction

endpackage

>>> sv/hhp_in_if.sv
`timescale 1ns / 1ps
interface hhp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

>>> sv/hhp_out_if.sv
`timescale 1ns / 1ps
interface hhp_out_if import hhp_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic                   keep_alive;
    logic [LENGTH_BITS-1:0] content_length;
    logic                   length_given;
    logic                   type_given;
    logic                   host_given;
    logic [1:0]             version_class;
    logic                   method_post;
    modport source (output valid, output status, output keep_alive, output content_length,
                    output length_given, output type_given, output host_given,
                    output version_class, output method_post, input ready);
    modport sink   (input valid, input status, input keep_alive, input content_length,
                    input length_given, input type_given, input host_given,
                    input version_class, input method_post, output ready);
endinterface

>>> sv/hhp_cfg_if.sv
`timescale 1ns / 1ps
interface hhp_cfg_if;
    logic valid;
    logic ready;
    logic parse_mode;
    modport source (output valid, output parse_mode, input ready);
    modport sink   (input valid, input parse_mode, output ready);
endinterface

>>> sv/http_header_parser_top.sv
`timescale 1ns / 1ps
// An accepted input beat is registered, and its result beat shows on o_out in the cycle after.
// Throughput: one byte per cycle while the result side takes every beat.
// Reset: i_rst_n is synchronous and active low; it clears the parse state,
// sets parse_mode to request and empties the result register.
// Opcode restart clears the parse state but keeps parse_mode.
module http_header_parser_top import hhp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hhp_in_if.sink    i_in,
    hhp_cfg_if.sink   i_cfg,
    hhp_out_if.source o_out
);

    // Parser state, the CR held back in case an LF follows, and the mode.
    t_st  r_st;
    t_st  n_st;
    logic r_cr;
    logic n_cr;
    logic r_mode;
    logic r_ovalid;

    logic accept;
    logic req;

    // The result register frees up when it is empty or its beat is taken
    // in this cycle, so a new byte can enter every cycle while the result side takes every beat.
    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign req = !r_mode;

    // One whole byte step. A held CR that is not followed by LF is fed in
    // as ordinary data ahead of the new byte, so the step may run the
    // character update twice.
    always_comb begin
        t_st s;
        s = r_st;
        n_cr = r_cr;
        unique case (i_in.opcode)
            OP_RESTART: begin
                s = ST_RESET;
                n_cr = 1'b0;
            end
            OP_EOF: if (r_st.status == ST_INCOMPLETE) s.status = ST_FAULT;
            OP_DATA: if (r_st.status == ST_INCOMPLETE) begin
                if (i_in.data_byte == CH_LF) begin
                    n_cr = 1'b0;
                    s = end_line(s, req);
                end else begin
                    if (r_cr) s = content_char(s, CH_CR, req);
                    n_cr = (i_in.data_byte == CH_CR);
                    if (i_in.data_byte != CH_CR) s = content_char(s, i_in.data_byte, req);
                end
            end
            default: s = r_st;
        endcase
        n_st = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_RESET;
            r_cr     <= 1'b0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_mode <= i_cfg.parse_mode;
            if (accept) begin
                r_st <= n_st;
                r_cr <= n_cr;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The result beat shows the state after the byte; the state register
    // is only written on accept, so it holds steady while a beat waits.
    assign o_out.valid          = r_ovalid;
    assign o_out.status         = r_st.status;
    assign o_out.keep_alive     = r_st.keep_alive;
    assign o_out.content_length = r_st.seen[0] ? r_st.accum : '0;
    assign o_out.length_given   = r_st.seen[0];
    assign o_out.type_given     = r_st.seen[1];
    assign o_out.host_given     = r_st.seen[2];
    assign o_out.version_class  = r_st.seen[5:4];
    assign o_out.method_post    = r_st.seen[3];

endmodule

>>> sim/http_header_parser_top_test.sv
`timescale 1ns / 1ps
module http_header_parser_top_test;
    import hhp_pkg::*;

    // One input beat: an opcode and the byte that goes with it.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_hdr_beat;

    // One result beat, field by field as the block reports it.
    typedef struct packed {
        logic [1:0]             status;
        logic                   keep_alive;
        logic [LENGTH_BITS-1:0] content_length;
        logic                   length_given;
        logic                   type_given;
        logic                   host_given;
        logic [1:0]             version_class;
        logic                   method_post;
    } t_hdr_result;

    // Parse state kept by the predictor.
    typedef struct {
        logic [2:0]  phase;
        logic        cr_held;
        logic [3:0]  pos;
        logic [3:0]  keys;
        logic [1:0]  vals;
        logic        trail_blank;
        logic [LENGTH_BITS-1:0] len;
        logic        neg;
        logic [1:0]  num_state;
        logic        have_len;
        logic        have_type;
        logic        have_host;
        logic        is_post;
        logic [1:0]  ver;
        logic [1:0]  status;
        logic        persist;
    } t_parse_state;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic MODE_REQ  = 1'b0;
    localparam logic MODE_RESP = 1'b1;

    logic i_clk;
    logic i_rst_n;

    hhp_in_if  in_ch();
    hhp_cfg_if cfg_ch();
    hhp_out_if out_ch();

    http_header_parser_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_hdr_beat    pending_beats[$];
    t_hdr_result  expected_results[$];
    t_parse_state ps;
    logic        mode;
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          stimulus_done = 0;
    bit          in_taken = 0;

    // Gap length: mostly zero or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_space_tab(input logic [7:0] c);
        return c == " " || c == 8'h09;
    endfunction

    function automatic bit text_eq(input string s, input logic [3:0] p,
                                   input logic [7:0] c);
        return int'(p) < s.len() && s[p] == c;
    endfunction

    function automatic void clear_state();
        ps.phase = P_F0; ps.cr_held = 0; ps.pos = 0; ps.keys = 4'hF;
        ps.vals = 2'b11; ps.trail_blank = 0; ps.len = '0; ps.neg = 0;
        ps.num_state = NP_SKIP; ps.have_len = 0; ps.have_type = 0;
        ps.have_host = 0; ps.is_post = 0; ps.ver = 0;
        ps.status = ST_INCOMPLETE; ps.persist = 1;
    endfunction

    function automatic void bump_pos();
        if (ps.pos != 4'd15) ps.pos = ps.pos + 4'd1;
    endfunction

    // Start line: bit 0 POST, bit 1 the HTTP/ prefix, bits 2 and 3 the versions.
    function automatic void scan_version(input logic [7:0] c);
        if (ps.pos < 5) begin
            if (!text_eq("HTTP/", ps.pos, c)) ps.keys[1] = 0;
        end else if (ps.pos < 8) begin
            if (!text_eq("1.0", ps.pos - 4'd5, c)) ps.keys[2] = 0;
            if (!text_eq("1.1", ps.pos - 4'd5, c)) ps.keys[3] = 0;
        end else begin
            ps.keys[3:2] = 0;
        end
        bump_pos();
    endfunction

    function automatic void close_version();
        if (ps.pos < 5 || !ps.keys[1]) ps.keys[3:1] = 0;
        if (ps.pos != 8) ps.keys[3:2] = 0;
    endfunction

    function automatic void scan_key(input logic [7:0] c);
        logic [7:0] l;
        l = fold_case(c);
        if (c == ":") begin
            if (ps.pos != 14) ps.keys[0] = 0;
            if (ps.pos != 4)  ps.keys[1] = 0;
            if (ps.pos != 12) ps.keys[2] = 0;
            if (ps.pos != 10) ps.keys[3] = 0;
            ps.phase = P_VLEAD; ps.pos = 0; ps.vals = 2'b11;
            ps.trail_blank = 0; ps.neg = 0; ps.num_state = NP_SKIP;
            if (ps.keys[0] && !ps.have_len) ps.len = '0;
        end else begin
            if (!text_eq("content-length", ps.pos, l)) ps.keys[0] = 0;
            if (!text_eq("host", ps.pos, l))           ps.keys[1] = 0;
            if (!text_eq("content-type", ps.pos, l))   ps.keys[2] = 0;
            if (!text_eq("connection", ps.pos, l))     ps.keys[3] = 0;
            bump_pos();
        end
    endfunction

    function automatic void scan_value(input logic [7:0] c);
        bit digit;
        bit take;
        longint unsigned acc;
        digit = c >= "0" && c <= "9";
        take = 0;
        if (ps.num_state == NP_SKIP) begin
            if (is_space_tab(c) || (c >= 8'd10 && c <= 8'd13)) take = 0;
            else if (c == "+" || c == "-") begin
                ps.neg = (c == "-"); ps.num_state = NP_DIG;
            end else if (!digit) ps.num_state = NP_DONE;
            else begin
                ps.num_state = NP_DIG; take = 1;
            end
        end else if (ps.num_state == NP_DIG) begin
            if (!digit) ps.num_state = NP_DONE;
            else take = 1;
        end
        if (take && ps.keys[0] && !ps.have_len) begin
            acc = longint'(ps.len) * 10 + (c - "0");
            ps.len = (acc > longint'(LEN_MAX)) ? LEN_MAX : acc[LENGTH_BITS-1:0];
        end
        if (is_space_tab(c)) begin
            ps.trail_blank = 1;
        end else begin
            if (ps.trail_blank) ps.vals = 0;
            ps.trail_blank = 0;
            if (!text_eq("keep-alive", ps.pos, fold_case(c))) ps.vals[0] = 0;
            if (!text_eq("close", ps.pos, fold_case(c)))      ps.vals[1] = 0;
            bump_pos();
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        bit req;
        req = (mode == MODE_REQ);
        case (ps.phase)
            P_F0, P_F1: begin
                if (c == " ") begin
                    if (ps.phase == P_F0) begin
                        if (req) begin
                            if (ps.pos != 4) ps.keys[0] = 0;
                        end else begin
                            close_version();
                        end
                    end
                    ps.phase = ps.phase + 3'd1;
                    ps.pos = 0;
                end else if (ps.phase == P_F0) begin
                    if (req) begin
                        if (!text_eq("POST", ps.pos, c)) ps.keys[0] = 0;
                        bump_pos();
                    end else begin
                        scan_version(c);
                    end
                end
            end
            P_F2: if (req) scan_version(c);
            P_LEAD: begin
                if (is_space_tab(c)) begin
                    bump_pos();
                end else begin
                    ps.phase = P_KEY; ps.pos = 0; ps.keys = 4'hF;
                    scan_key(c);
                end
            end
            P_KEY: scan_key(c);
            P_VLEAD: if (!is_space_tab(c)) begin
                ps.phase = P_VAL;
                scan_value(c);
            end
            P_VAL: scan_value(c);
            default: ;
        endcase
    endfunction

    function automatic void finish_line();
        bit req;
        req = (mode == MODE_REQ);
        if (ps.phase <= P_F2) begin
            if (ps.phase != P_F2) begin
                ps.status = ST_FAULT; return;
            end
            if (req) begin
                close_version();
                if (ps.keys[0]) ps.is_post = 1;
            end
            if (!ps.keys[1]) begin
                ps.status = ST_FAULT; return;
            end
            ps.ver = ps.keys[2] ? 2'd1 : (ps.keys[3] ? 2'd2 : 2'd0);
            if (ps.ver == 2'd1) ps.persist = 0;
        end else if (ps.phase == P_LEAD) begin
            // A blank line ends the header and applies the final checks.
            if (ps.pos != 0) ps.status = ST_FAULT;
            else if (req)
                ps.status = ((ps.ver == 2'd2 && !ps.have_host) ||
                             (!ps.have_len && ps.is_post)) ? ST_FAULT : ST_COMPLETE;
            else ps.status = ps.have_len ? ST_COMPLETE : ST_FAULT;
            return;
        end else if (ps.phase != P_VAL) begin
            ps.status = ST_FAULT; return;
        end else if (ps.keys[0]) begin
            if (ps.have_len || (ps.neg && ps.len != 0)) begin
                ps.status = ST_FAULT; return;
            end
            ps.have_len = 1;
        end else if (ps.keys[1]) begin
            if (req) ps.have_host = 1;
        end else if (ps.keys[2]) begin
            if (ps.have_type) begin
                ps.status = ST_FAULT; return;
            end
            ps.have_type = 1;
        end else if (ps.keys[3]) begin
            if (ps.vals[0] && ps.pos == 10) ps.persist = 1;
            else if (ps.vals[1] && ps.pos == 5) ps.persist = 0;
        end
        ps.phase = P_LEAD;
        ps.pos = 0;
    endfunction

    // Advances the predicted parser by one beat and returns what it reports.
    function automatic t_hdr_result predict_parse(input t_hdr_beat b);
        t_hdr_result r;
        if (b.opcode == OP_RESTART) begin
            clear_state();
        end else if (b.opcode == OP_EOF) begin
            if (ps.status == ST_INCOMPLETE) ps.status = ST_FAULT;
        end else if (b.opcode == OP_DATA && ps.status == ST_INCOMPLETE) begin
            if (b.data_byte == CH_LF) begin
                ps.cr_held = 0;
                finish_line();
            end else begin
                if (ps.cr_held) begin
                    ps.cr_held = 0;
                    take_char(CH_CR);
                end
                if (b.data_byte == CH_CR) ps.cr_held = 1;
                else take_char(b.data_byte);
            end
        end
        r.status = ps.status;
        r.keep_alive = ps.persist;
        r.content_length = ps.have_len ? ps.len : '0;
        r.length_given = ps.have_len;
        r.type_given = ps.have_type;
        r.host_given = ps.have_host;
        r.version_class = ps.ver;
        r.method_post = ps.is_post;
        return r;
    endfunction

    task automatic push_byte(input logic [1:0] op, input logic [7:0] b);
        t_hdr_beat x;
        x.opcode = op;
        x.data_byte = b;
        pending_beats.push_back(x);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(OP_DATA, s[i]);
    endtask

    // Driver: presents queued beats at the falling edge, with random gaps.
    // A beat stays on the bus until the rising edge has taken it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // Hold the beat until it is taken.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            in_ch.valid <= 1'b1;
            {in_ch.opcode, in_ch.data_byte} <= pending_beats.pop_front();
            send_gap <= pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // The predictor follows every accepted input beat.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken)
            expected_results.push_back(predict_parse({in_ch.opcode, in_ch.data_byte}));
    end

    // Result side backpressure, changed at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_hdr_result got;
        t_hdr_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = out_ch.status;
            got.keep_alive = out_ch.keep_alive;
            got.content_length = out_ch.content_length;
            got.length_given = out_ch.length_given;
            got.type_given = out_ch.type_given;
            got.host_given = out_ch.host_given;
            got.version_class = out_ch.version_class;
            got.method_post = out_ch.method_post;
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat at %0t: %p", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("Result mismatch at %0t: expected %p, got %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    // Waits until the block has drained, then writes parse_mode.
    task automatic set_mode(input logic m);
        @(posedge i_clk);
        while (pending_beats.size() != 0 || in_ch.valid ||
               expected_results.size() != 0 || out_ch.valid)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.parse_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        mode = m;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Builds one header with random content, mostly well formed.
    task automatic push_header(input logic m);
        string ver;
        int n;
        int k;
        push_byte(OP_RESTART, 8'($urandom));
        case ($urandom_range(0, 3))
            0: ver = "1.0";
            1, 2: ver = "1.1";
            default: ver = "2";
        endcase
        if (m == MODE_REQ) begin
            if ($urandom_range(0, 1)) push_text("POST");
            else push_text("GET");
            push_text(" /x ");
            push_text({"HTTP/", ver});
        end else begin
            push_text({"HTTP/", ver, " 200 OK"});
        end
        if ($urandom_range(0, 1)) push_text("\r\n");
        else push_text("\n");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) push_text(" \t");
            case (k)
                0, 1: begin
                    if ($urandom_range(0, 1)) push_text("Content-Length:");
                    else push_text("content-length: ");
                    if ($urandom_range(0, 5) == 0) push_byte(OP_DATA, "-");
                    repeat ($urandom_range(1, 12))
                        push_byte(OP_DATA, 8'("0" + $urandom_range(0, 9)));
                end
                2: push_text("Host: h");
                3: push_text("Content-Type: a/b ");
                4: begin
                    if ($urandom_range(0, 1)) push_text("Connection: Keep-Alive");
                    else push_text("connection:\tclose ");
                end
                5: push_text("Connection: keep alive");
                6: push_text("Host :x");
                7: begin
                    if ($urandom_range(0, 1)) push_text("novalue");
                    else push_text("X-A:");
                end
                default: repeat ($urandom_range(1, 20))
                    push_byte(OP_DATA, 8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 7) == 0) push_text("\r\r\n");
            else push_text("\r\n");
        end
        if ($urandom_range(0, 7) != 0) push_text("\r\n");
        // Trailing bytes or opcodes after the end of the header.
        case ($urandom_range(0, 5))
            0: push_byte(OP_EOF, 8'($urandom));
            1: push_byte(OP_UNUSED, 8'($urandom));
            2: push_byte(OP_DATA, 8'($urandom));
            default: ;
        endcase
    endtask

    initial begin
        int sent;
        int queued;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_DATA;
        in_ch.data_byte = 8'd0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.parse_mode = MODE_REQ;
        mode = MODE_REQ;
        clear_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a POST request with every header and the edge cases.
        push_text("POST / HTTP/1.1\r\nHost: a\r\ncontent-length: 99999999999\r\n");
        push_text("Content-Type: t\r\nConnection: close\r\n\r\n");
        push_byte(OP_DATA, 8'hFF);
        push_byte(OP_EOF, 8'h00);
        push_byte(OP_UNUSED, 8'hAA);
        push_byte(OP_RESTART, 8'h55);
        push_text("GET /x\n");
        push_byte(OP_RESTART, 8'h00);
        push_text("GET / HTTP/1.0\ncontent-length: -0\ncontent-length: 1\n");
        push_byte(OP_RESTART, 8'h00);
        push_text("a b HTTP/1.0\nContent-Length: -5\n");
        push_byte(OP_RESTART, 8'h00);
        push_text("a b HTTP/1.1\r\nhost: \r\n");
        push_byte(OP_RESTART, 8'h00);
        push_text("a b HTTP/1.1\nHOST:z\nhost:y\ncontent-type:a\ncontent-type:b\n");
        push_byte(OP_RESTART, 8'h00);
        push_text("a b HTTP/1.1x\nhost\t:y\n \n");
        push_byte(OP_RESTART, 8'h00);
        push_text("a b c\rd\n");
        push_byte(OP_EOF, 8'h00);

        // The sender holds off here until every expectation is met.
        set_mode(MODE_RESP);
        push_byte(OP_RESTART, 8'h00);
        push_text("HTTP/1.0 200 OK\r\nContent-Length: 7\r\n\r\n");
        set_mode(MODE_REQ);

        sent = 0;
        for (int phase_no = 0; phase_no < 8; phase_no++) begin
            if (phase_no > 0) set_mode(phase_no[0] ? MODE_RESP : MODE_REQ);
            while (sent < (phase_no + 1) * 150) begin
                queued = pending_beats.size();
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 20))
                        push_byte(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end else begin
                    push_header(mode);
                end
                sent = sent + pending_beats.size() - queued;
                wait (pending_beats.size() < 4);
            end
        end
        @(posedge i_clk);
        while (pending_beats.size() != 0 || in_ch.valid) @(posedge i_clk);
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> http_header_parser_top.f
sv/hhp_pkg.sv
sv/hhp_in_if.sv
sv/hhp_out_if.sv
sv/hhp_cfg_if.sv
sv/http_header_parser_top.sv
sim/http_header_parser_top_test.sv
